### rtl/deq_pkg.sv
package deq_pkg;

	localparam int DEPTH   = 16;
	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int WORD_W  = 32;
	localparam int MODE_W  = 3;
	localparam int COUNT_W = 5;

	localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
	localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_QUERY      = 3'd4;

	localparam logic [WORD_W-1:0] EMPTY_WORD = '1;

	typedef struct packed {
		logic exec;
		logic rd;
		logic load;
	} deq_cmd_t;

endpackage

### rtl/double_ended_queue_core.sv
// channel   signals                       word
// input     in_valid / in_ready           mode, push_value
// output    out_valid / out_ready         front_value, back_value, count, is_empty, op_error
//
// For each word, the accept step updates the pointers and writes the slot RAM,
// the read state reads both ends from the RAM, and the done state loads the output register.
// A new word is accepted while a finished result waits in the output register.
// A stalled output holds the next result in the done state until the register frees.
// Reset clears the head pointer and count; the slot RAM is not cleared.
module double_ended_queue_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [deq_pkg::MODE_W-1:0]        mode,
	input  logic signed [deq_pkg::WORD_W-1:0] push_value,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [deq_pkg::WORD_W-1:0] front_value,
	output logic signed [deq_pkg::WORD_W-1:0] back_value,
	output logic [deq_pkg::COUNT_W-1:0]       count,
	output logic                              is_empty,
	output logic                              op_error
);

	import deq_pkg::*;

	deq_cmd_t cmd;

	deq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	deq_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.mode        (mode),
		.push_value  (push_value),
		.front_value (front_value),
		.back_value  (back_value),
		.count       (count),
		.is_empty    (is_empty),
		.op_error    (op_error)
	);

`ifndef SYNTHESIS
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second word accepted while one is in flight");

	a_empty_values: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_empty |-> (front_value == -32'sd1) && (back_value == -32'sd1))
		else $error("empty result without all-ones values");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (is_empty == (count == '0)))
		else $error("empty flag disagrees with count");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (count <= COUNT_W'(DEPTH)))
		else $error("count exceeds depth");
`endif

endmodule

### rtl/deq_ram.sv
module deq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem_q[raddr_a];
			rdata_b <= mem_q[raddr_b];
		end
	end

endmodule

### rtl/deq_ctrl.sv
module deq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output deq_pkg::deq_cmd_t cmd
);

	import deq_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_READ = 2'd1;
	localparam logic [1:0] S_DONE = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d  = state_q;
		cmd.exec = 1'b0;
		cmd.rd   = 1'b0;
		cmd.load = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.exec = 1'b1;
					state_d  = S_READ;
				end
			end
			S_READ: begin
				cmd.rd  = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				// hold the result until the output register is free
				if (!out_valid_q || out_ready) begin
					cmd.load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### rtl/deq_dp.sv
module deq_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  deq_pkg::deq_cmd_t               cmd,
	input  logic [deq_pkg::MODE_W-1:0]      mode,
	input  logic signed [deq_pkg::WORD_W-1:0] push_value,
	output logic signed [deq_pkg::WORD_W-1:0] front_value,
	output logic signed [deq_pkg::WORD_W-1:0] back_value,
	output logic [deq_pkg::COUNT_W-1:0]     count,
	output logic                            is_empty,
	output logic                            op_error
);

	import deq_pkg::*;

	logic [ADDR_W-1:0] head_q;
	logic [CNT_W-1:0]  count_q;
	logic              err_q;

	logic [ADDR_W-1:0] head_d;
	logic [CNT_W-1:0]  count_d;
	logic              err_d;

	logic [ADDR_W-1:0] head_prev;
	logic [ADDR_W-1:0] head_next;
	logic [CNT_W:0]    tail_sum;
	logic [ADDR_W-1:0] tail_idx;
	logic [ADDR_W-1:0] back_idx;
	logic              is_full;
	logic              is_zero;

	logic              we;
	logic [ADDR_W-1:0] waddr;
	logic [WORD_W-1:0] rdata_a;
	logic [WORD_W-1:0] rdata_b;

	logic [WORD_W-1:0]  front_q;
	logic [WORD_W-1:0]  back_q;
	logic [COUNT_W-1:0] cnt_out_q;
	logic               empty_q;
	logic               error_q;

	assign is_full = (count_q == CNT_W'(DEPTH));
	assign is_zero = (count_q == '0);

	assign head_prev = (head_q == '0) ? ADDR_W'(DEPTH - 1) : head_q - 1'b1;
	assign head_next = (head_q == ADDR_W'(DEPTH - 1)) ? '0 : head_q + 1'b1;

	// slot just past the back; sum stays below twice the depth
	assign tail_sum = (CNT_W + 1)'(head_q) + (CNT_W + 1)'(count_q);
	assign tail_idx = (tail_sum >= (CNT_W + 1)'(DEPTH)) ?
		ADDR_W'(tail_sum - (CNT_W + 1)'(DEPTH)) : ADDR_W'(tail_sum);
	assign back_idx = (tail_idx == '0) ? ADDR_W'(DEPTH - 1) : tail_idx - 1'b1;

	always_comb begin
		head_d  = head_q;
		count_d = count_q;
		err_d   = 1'b0;
		we      = 1'b0;
		waddr   = tail_idx;
		case (mode)
			MODE_PUSH_FRONT: begin
				if (is_full) begin
					err_d = 1'b1;
				end else begin
					we      = 1'b1;
					waddr   = head_prev;
					head_d  = head_prev;
					count_d = count_q + 1'b1;
				end
			end
			MODE_PUSH_BACK: begin
				if (is_full) begin
					err_d = 1'b1;
				end else begin
					we      = 1'b1;
					count_d = count_q + 1'b1;
				end
			end
			MODE_POP_FRONT: begin
				if (is_zero) begin
					err_d = 1'b1;
				end else begin
					head_d  = head_next;
					count_d = count_q - 1'b1;
				end
			end
			MODE_POP_BACK: begin
				if (is_zero) begin
					err_d = 1'b1;
				end else begin
					count_d = count_q - 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
			err_q   <= 1'b0;
		end else if (cmd.exec) begin
			head_q  <= head_d;
			count_q <= count_d;
			err_q   <= err_d;
		end
	end

	deq_ram #(
		.WIDTH (WORD_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk     (clk),
		.we      (cmd.exec && we),
		.waddr   (waddr),
		.wdata   (push_value),
		.re      (cmd.rd),
		.raddr_a (head_q),
		.raddr_b (back_idx),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			front_q   <= is_zero ? EMPTY_WORD : rdata_a;
			back_q    <= is_zero ? EMPTY_WORD : rdata_b;
			cnt_out_q <= COUNT_W'(count_q);
			empty_q   <= is_zero;
			error_q   <= err_q;
		end
	end

	assign front_value = front_q;
	assign back_value  = back_q;
	assign count       = cnt_out_q;
	assign is_empty    = empty_q;
	assign op_error    = error_q;

endmodule

### tb/sv/tb_double_ended_queue_core.sv
module tb_double_ended_queue_core;
	import deq_pkg::*;

	localparam int RANDOM_WORDS   = 1250;
	localparam int LONG_HOLD      = 200;
	localparam int LONG_HOLD_AT   = 400;
	localparam int PAUSE_AT       = 700;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int SETTLE_CYCLES  = 10;
	localparam int REPORT_MAX     = 10;

	typedef struct packed {
		logic signed [WORD_W-1:0] front_word;
		logic signed [WORD_W-1:0] back_word;
		logic [COUNT_W-1:0]       occupancy;
		logic                     empty_flag;
		logic                     error_flag;
	} deq_result_t;

	typedef struct {
		logic [MODE_W-1:0]        op;
		logic signed [WORD_W-1:0] value;
		bit                       typed;
		deq_result_t              want;
	} stim_row_t;

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_ready;
	logic [MODE_W-1:0]         mode;
	logic signed [WORD_W-1:0]  push_value;
	logic                      out_valid;
	logic                      out_ready;
	logic signed [WORD_W-1:0]  front_value;
	logic signed [WORD_W-1:0]  back_value;
	logic [COUNT_W-1:0]        count;
	logic                      is_empty;
	logic                      op_error;

	// sideband travelling with each word: a typed-in expectation for directed rows
	bit                        word_typed;
	deq_result_t               word_want;

	logic signed [WORD_W-1:0]  ring_store [DEPTH];
	int                        ring_head;
	int                        ring_fill;

	deq_result_t               result_q [$];
	stim_row_t                 plan [$];
	int                        results_due;
	int                        words_in;
	int                        results_seen;
	int                        mismatches;
	int                        full_drops;
	int                        empty_pops;
	int                        full_hits;
	int                        idle_cycles;
	bit                        draining;
	bit                        long_hold_done;

	double_ended_queue_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(mode),
		.push_value(push_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.front_value(front_value),
		.back_value(back_value),
		.count(count),
		.is_empty(is_empty),
		.op_error(op_error)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Apply one operation to the ring and return the ends, count and flags.
	function automatic deq_result_t step_deque(input logic [MODE_W-1:0] op,
			input logic signed [WORD_W-1:0] v);
		deq_result_t r;
		r.error_flag = 1'b0;
		case (op)
			MODE_PUSH_FRONT: begin
				if (ring_fill >= DEPTH) begin
					r.error_flag = 1'b1;
					full_drops++;
				end else begin
					ring_head = (ring_head + DEPTH - 1) % DEPTH;
					ring_store[ring_head] = v;
					ring_fill++;
				end
			end
			MODE_PUSH_BACK: begin
				if (ring_fill >= DEPTH) begin
					r.error_flag = 1'b1;
					full_drops++;
				end else begin
					ring_store[(ring_head + ring_fill) % DEPTH] = v;
					ring_fill++;
				end
			end
			MODE_POP_FRONT: begin
				if (ring_fill == 0) begin
					r.error_flag = 1'b1;
					empty_pops++;
				end else begin
					ring_head = (ring_head + 1) % DEPTH;
					ring_fill--;
				end
			end
			MODE_POP_BACK: begin
				if (ring_fill == 0) begin
					r.error_flag = 1'b1;
					empty_pops++;
				end else begin
					ring_fill--;
				end
			end
			default: begin
			end
		endcase
		if (ring_fill == DEPTH)
			full_hits++;
		if (ring_fill == 0) begin
			r.front_word = EMPTY_WORD;
			r.back_word  = EMPTY_WORD;
		end else begin
			r.front_word = ring_store[ring_head];
			r.back_word  = ring_store[(ring_head + ring_fill - 1) % DEPTH];
		end
		r.occupancy  = COUNT_W'(ring_fill);
		r.empty_flag = (ring_fill == 0);
		return r;
	endfunction

	function automatic void add_row(input logic [MODE_W-1:0] op,
			input logic signed [WORD_W-1:0] v, input bit typed, input deq_result_t want);
		stim_row_t row;
		row.op    = op;
		row.value = v;
		row.typed = typed;
		row.want  = want;
		plan.insert(plan.size(), row);
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic logic signed [WORD_W-1:0] pick_word();
		case ($urandom_range(0, 9))
			0: return 32'sh7fff_ffff;
			1: return 32'sh8000_0000;
			2: return -32'sd1;
			3: return 32'sd0;
			default: return $urandom;
		endcase
	endfunction

	task automatic drive_word(input logic [MODE_W-1:0] op, input logic signed [WORD_W-1:0] v,
			input bit typed, input deq_result_t want, input bit no_gap);
		int g;
		@(negedge clk);
		in_valid   <= 1'b1;
		mode       <= op;
		push_value <= v;
		word_typed <= typed;
		word_want  <= want;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		g = no_gap ? 0 : pick_gap();
		if (g > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (g - 1) @(negedge clk);
		end
	endtask

	// Predict on the input handshake, check on the output handshake.
	always @(posedge clk) begin : scoreboard
		deq_result_t predicted;
		deq_result_t want;
		deq_result_t got;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				predicted = step_deque(mode, push_value);
				result_q.insert(result_q.size(), word_typed ? word_want : predicted);
				results_due++;
				words_in++;
			end
			if (out_valid && out_ready) begin
				got = {front_value, back_value, count, is_empty, op_error};
				results_seen++;
				if (result_q.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_MAX) begin
						$display("result %0d arrived with nothing expected:",
							results_seen);
						$display("  got front=%0d back=%0d count=%0d empty=%b err=%b",
							got.front_word, got.back_word, got.occupancy,
							got.empty_flag, got.error_flag);
					end
				end else begin
					want = result_q[0];
					result_q.delete(0);
					results_due--;
					if (got !== want) begin
						mismatches++;
						if (mismatches <= REPORT_MAX) begin
							$display("result %0d mismatch:", results_seen);
							$display("  exp front=%0d back=%0d count=%0d empty=%b err=%b",
								want.front_word, want.back_word, want.occupancy,
								want.empty_flag, want.error_flag);
							$display("  got front=%0d back=%0d count=%0d empty=%b err=%b",
								got.front_word, got.back_word, got.occupancy,
								got.empty_flag, got.error_flag);
						end
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no word moved for %0d cycles, %0d results outstanding",
					idle_cycles, results_due);
				$display("Verification failed");
				$finish;
			end
		end
	end

	// Receiver: random stalls, free-running stretches, and one long hold to back the block up.
	initial begin : receiver
		int rx_hold;
		int rx_free;
		rx_hold = 0;
		rx_free = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (draining) begin
				out_ready <= 1'b1;
			end else if (!long_hold_done && words_in >= LONG_HOLD_AT) begin
				long_hold_done = 1'b1;
				rx_hold = LONG_HOLD - 1;
				out_ready <= 1'b0;
			end else if (rx_hold > 0) begin
				rx_hold--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (rx_free > 0)
					rx_free--;
				else if ($urandom_range(0, 19) == 0)
					rx_free = $urandom_range(30, 100);
				else if ($urandom_range(0, 3) == 0)
					rx_hold = pick_gap();
			end
		end
	end

	initial begin : sender
		int push_pct;
		int r;
		bit tx_calm;
		logic [MODE_W-1:0] op;

		arst_n      = 1'b0;
		in_valid    = 1'b0;
		mode        = MODE_QUERY;
		push_value  = '0;
		word_typed  = 1'b0;
		word_want   = '0;
		ring_head   = 0;
		ring_fill   = 0;
		results_due = 0;
		words_in    = 0;
		results_seen = 0;
		mismatches  = 0;
		full_drops  = 0;
		empty_pops  = 0;
		full_hits   = 0;
		idle_cycles = 0;
		draining    = 1'b0;
		long_hold_done = 1'b0;
		push_pct    = 50;
		tx_calm     = 1'b0;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty queue: ends read as all ones, pops are refused; then push at both ends and pop back to empty
		add_row(MODE_QUERY,      32'sd5, 1'b1, '{-32'sd1, -32'sd1, 5'd0, 1'b1, 1'b0});
		add_row(MODE_POP_FRONT,  32'sd0, 1'b1, '{-32'sd1, -32'sd1, 5'd0, 1'b1, 1'b1});
		add_row(MODE_POP_BACK,   32'sd0, 1'b1, '{-32'sd1, -32'sd1, 5'd0, 1'b1, 1'b1});
		add_row(3'd5,            32'sd9, 1'b1, '{-32'sd1, -32'sd1, 5'd0, 1'b1, 1'b0});
		add_row(MODE_PUSH_FRONT, 32'sh7fff_ffff, 1'b1,
			'{32'sh7fff_ffff, 32'sh7fff_ffff, 5'd1, 1'b0, 1'b0});
		add_row(MODE_PUSH_BACK,  32'sh8000_0000, 1'b1,
			'{32'sh7fff_ffff, 32'sh8000_0000, 5'd2, 1'b0, 1'b0});
		add_row(3'd7,            32'sd0, 1'b0, '0);
		add_row(MODE_POP_BACK,   32'sd0, 1'b1,
			'{32'sh7fff_ffff, 32'sh7fff_ffff, 5'd1, 1'b0, 1'b0});
		add_row(MODE_POP_FRONT,  32'sd0, 1'b1, '{-32'sd1, -32'sd1, 5'd0, 1'b1, 1'b0});
		// fill to capacity from both ends, then push into a full queue
		for (int i = 0; i < DEPTH; i++)
			add_row((i % 2) ? MODE_PUSH_BACK : MODE_PUSH_FRONT,
				(i == 3) ? -32'sd1 : (i == 6) ? 32'sd0 : $urandom, 1'b0, '0);
		add_row(MODE_PUSH_FRONT, 32'sd123, 1'b0, '0);
		add_row(MODE_PUSH_BACK,  -32'sd456, 1'b0, '0);

		foreach (plan[i])
			drive_word(plan[i].op, plan[i].value, plan[i].typed, plan[i].want, 1'b0);

		for (int i = 0; i < RANDOM_WORDS; i++) begin
			// swing between filling, draining and balanced traffic
			if (i % 64 == 0) begin
				case ($urandom_range(0, 2))
					0: push_pct = 75;
					1: push_pct = 20;
					default: push_pct = 47;
				endcase
				tx_calm = ($urandom_range(0, 3) == 0);
			end
			if (i == PAUSE_AT) begin
				@(negedge clk);
				in_valid <= 1'b0;
				wait (results_due == 0);
			end
			r = $urandom_range(0, 99);
			if (r < 6)
				op = MODE_W'($urandom_range(4, 7));
			else if (r < 6 + push_pct)
				op = $urandom_range(0, 1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT;
			else
				op = $urandom_range(0, 1) ? MODE_POP_BACK : MODE_POP_FRONT;
			drive_word(op, pick_word(), 1'b0, '0, tx_calm);
		end

		@(negedge clk);
		in_valid <= 1'b0;
		draining = 1'b1;
		wait (results_due == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Ran %0d words and checked %0d results; the queue was full %0d times,",
			words_in, results_seen, full_hits);
		$display("with %0d pushes refused when full and %0d pops refused when empty.",
			full_drops, empty_pops);
		if (mismatches == 0 && result_q.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("%0d mismatches, %0d results still outstanding", mismatches, result_q.size());
			$display("Verification failed");
		end
		$finish;
	end

endmodule
